@@ design/ray_ground_point_classifier_top_defines.svh @@
// Assertion macros shared by the classifier RTL.
// Each macro expands to one labeled concurrent assertion that is disabled during reset.
`ifndef RAY_GROUND_POINT_CLASSIFIER_TOP_DEFINES_SVH
`define RAY_GROUND_POINT_CLASSIFIER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RGPC_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rgpc same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define RGPC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rgpc next-cycle check failed");

`endif

@@ design/rgpc_pkg.sv @@
`timescale 1ns / 1ps
package rgpc_pkg;

  localparam int RADIUS_W    = 18;
  localparam int HEIGHT_W    = 20;
  localparam int INDEX_W     = 16;
  localparam int CFG_W       = 16;
  localparam int REG_INDEX_W = 3;

  // A radial step spans both signs of the radius range.
  localparam int STEP_W = RADIUS_W + 1;
  // Signed product of a Q0.16 tangent (zero-extended) and a step.
  localparam int PROD_W = CFG_W + STEP_W + 1;
  // Threshold after the shift by 16 keeps the width of the step.
  localparam int THR_W  = STEP_W;
  // Band limits are a height plus or minus a threshold.
  localparam int BAND_W = HEIGHT_W + 1;

  localparam logic [CFG_W-1:0] LOCAL_SLOPE_TAN_RST     = 16'd5734;
  localparam logic [CFG_W-1:0] GENERAL_SLOPE_TAN_RST   = 16'd3435;
  localparam logic [CFG_W-1:0] DIVIDER_DISTANCE_MM_RST = 16'd0;
  localparam logic [CFG_W-1:0] MIN_HEIGHT_MM_RST       = 16'd50;
  localparam logic [CFG_W-1:0] RECLASS_DISTANCE_MM_RST = 16'd200;

  typedef enum logic [REG_INDEX_W-1:0] {
    REG_LOCAL_SLOPE_TAN     = 3'd0,
    REG_GENERAL_SLOPE_TAN   = 3'd1,
    REG_DIVIDER_DISTANCE_MM = 3'd2,
    REG_MIN_HEIGHT_MM       = 3'd3,
    REG_RECLASS_DISTANCE_MM = 3'd4
  } reg_index_t;

  typedef struct packed {
    logic [CFG_W-1:0] local_slope_tan;
    logic [CFG_W-1:0] general_slope_tan;
    logic [CFG_W-1:0] divider_distance_mm;
    logic [CFG_W-1:0] min_height_mm;
    logic [CFG_W-1:0] reclass_distance_mm;
  } cfg_regs_t;

  // Input register: the step and the previous height are resolved against the ray start here.
  typedef struct packed {
    logic [STEP_W-1:0]   step;
    logic [RADIUS_W-1:0] radius;
    logic [HEIGHT_W-1:0] height;
    logic [HEIGHT_W-1:0] base_height;
    logic                first;
    logic [INDEX_W-1:0]  index;
  } stage_a_t;

  // Product register: floored thresholds and the step compares.
  typedef struct packed {
    logic [THR_W-1:0]    thr_raw;
    logic [RADIUS_W-1:0] gen;
    logic                gt_div;
    logic                gt_recl;
    logic [HEIGHT_W-1:0] height;
    logic [HEIGHT_W-1:0] base_height;
    logic                first;
    logic [INDEX_W-1:0]  index;
  } stage_b_t;

  // Band register: the three band tests.
  typedef struct packed {
    logic               in_band;
    logic               gen_ok;
    logic               recl_ok;
    logic               first;
    logic [INDEX_W-1:0] index;
  } stage_c_t;

endpackage

@@ design/rgpc_if.sv @@
`timescale 1ns / 1ps
// Point channel: one lidar point per beat.
interface rgpc_point_if import rgpc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                first_of_ray;
  logic [RADIUS_W-1:0] radius_mm;
  logic [HEIGHT_W-1:0] height_mm;
  logic [INDEX_W-1:0]  point_index;

  modport source (output valid, first_of_ray, radius_mm, height_mm, point_index,
                  input ready);
  modport sink (input valid, first_of_ray, radius_mm, height_mm, point_index,
                output ready);
endinterface

// Result channel: one classified point per beat.
interface rgpc_result_if import rgpc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [INDEX_W-1:0] out_index;
  logic               is_ground;

  modport source (output valid, out_index, is_ground, input ready);
  modport sink (input valid, out_index, is_ground, output ready);
endinterface

// Configuration write channel: register index and write data per beat.
interface rgpc_cfg_if import rgpc_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [REG_INDEX_W-1:0] index;
  logic [CFG_W-1:0]       data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ design/rgpc_cfg_regs.sv @@
`timescale 1ns / 1ps
// Register file for the classifier thresholds. Writes to unknown indexes are dropped.
module rgpc_cfg_regs import rgpc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  rgpc_cfg_if.sink  cfg,
  output cfg_regs_t regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.local_slope_tan     <= LOCAL_SLOPE_TAN_RST;
      regs.general_slope_tan   <= GENERAL_SLOPE_TAN_RST;
      regs.divider_distance_mm <= DIVIDER_DISTANCE_MM_RST;
      regs.min_height_mm       <= MIN_HEIGHT_MM_RST;
      regs.reclass_distance_mm <= RECLASS_DISTANCE_MM_RST;
    end else if (cfg.valid) begin
      case (reg_index_t'(cfg.index))
        REG_LOCAL_SLOPE_TAN:     regs.local_slope_tan     <= cfg.data;
        REG_GENERAL_SLOPE_TAN:   regs.general_slope_tan   <= cfg.data;
        REG_DIVIDER_DISTANCE_MM: regs.divider_distance_mm <= cfg.data;
        REG_MIN_HEIGHT_MM:       regs.min_height_mm       <= cfg.data;
        REG_RECLASS_DISTANCE_MM: regs.reclass_distance_mm <= cfg.data;
        default: begin
        end
      endcase
    end
  end

endmodule

@@ design/ray_ground_point_classifier_top.sv @@
`timescale 1ns / 1ps
// Ray ground classifier. Points of one angular ray enter on the points channel in order of
// rising radius, with first_of_ray set on the first point of each ray, and every point leaves
// on the results channel as its index plus a ground flag, in arrival order. The block takes
// one point per clock cycle when the results side keeps up, and a result passes through the
// input, product, band and output registers before it appears on the results channel. That
// layout is set by the Q0.16 multiplies by the slope tangents, which have a register stage
// of their own, and by the ground-flag recurrence, which closes through a single
// multiplexer in front of the output register. Each register stage has its own valid bit
// and takes a new beat whenever it is empty or the stage after it moves, so points keep
// flowing into free stages while a finished result waits to be taken. Thresholds are
// written on the cfg channel, which is always ready; they must only change while no point
// is in flight.
`include "ray_ground_point_classifier_top_defines.svh"

module ray_ground_point_classifier_top import rgpc_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  rgpc_point_if.sink      points,
  rgpc_result_if.source   results,
  rgpc_cfg_if.sink        cfg
);

  cfg_regs_t regs;

  rgpc_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  // Radius and height of the previously accepted point. These track the input side, so a
  // new point can compute its step without waiting for earlier points to finish.
  logic [RADIUS_W-1:0] last_radius;
  logic [HEIGHT_W-1:0] last_height;
  // Ground flag of the most recent point to reach the output register.
  logic                last_was_ground;

  logic     a_valid, b_valid, c_valid, o_valid;
  stage_a_t a_stage, a_next;
  stage_b_t b_stage, b_next;
  stage_c_t c_stage, c_next;
  logic [INDEX_W-1:0] o_index;
  logic               o_ground;
  logic               ground_next;

  logic o_free, c_free, b_free, a_free;
  logic in_acc;

  // Each stage can take a new beat when it is empty or when its contents move on.
  always_comb begin
    o_free = !o_valid || results.ready;
    c_free = !c_valid || o_free;
    b_free = !b_valid || c_free;
    a_free = !a_valid || b_free;
  end

  assign points.ready = a_free;
  assign in_acc       = points.valid && a_free;

  // Input stage: a ray start compares against zero radius and zero height.
  logic [RADIUS_W-1:0] base_radius;
  always_comb begin
    base_radius         = points.first_of_ray ? '0 : last_radius;
    a_next.step         = {1'b0, points.radius_mm} - {1'b0, base_radius};
    a_next.radius       = points.radius_mm;
    a_next.height       = points.height_mm;
    a_next.base_height  = points.first_of_ray ? '0 : last_height;
    a_next.first        = points.first_of_ray;
    a_next.index        = points.point_index;
  end

  // Product stage: the two tangent multiplies run side by side. Taking the bits above the
  // fraction of a signed product floors it toward minus infinity.
  logic signed [PROD_W-1:0]          local_prod;
  logic        [CFG_W+RADIUS_W-1:0]  gen_prod;
  always_comb begin
    local_prod = $signed({1'b0, regs.local_slope_tan}) * $signed(a_stage.step);
    gen_prod   = regs.general_slope_tan * a_stage.radius;

    b_next.thr_raw     = local_prod[CFG_W+STEP_W-1:CFG_W];
    b_next.gen         = gen_prod[CFG_W+RADIUS_W-1:CFG_W];
    b_next.gt_div      = $signed(a_stage.step) >
                         $signed({{(STEP_W-CFG_W){1'b0}}, regs.divider_distance_mm});
    b_next.gt_recl     = $signed(a_stage.step) >
                         $signed({{(STEP_W-CFG_W){1'b0}}, regs.reclass_distance_mm});
    b_next.height      = a_stage.height;
    b_next.base_height = a_stage.base_height;
    b_next.first       = a_stage.first;
    b_next.index       = a_stage.index;
  end

  // Band stage: raise the local threshold for long steps, then test the three bands.
  logic signed [THR_W-1:0]  min_thr;
  logic signed [THR_W-1:0]  thr_c;
  logic signed [BAND_W-1:0] h_w, ph_w, thr_w, gen_w, band_hi, band_lo;
  always_comb begin
    min_thr = $signed({{(THR_W-CFG_W){1'b0}}, regs.min_height_mm});
    thr_c   = (b_stage.gt_div && ($signed(b_stage.thr_raw) < min_thr)) ?
              min_thr : $signed(b_stage.thr_raw);

    h_w     = $signed({b_stage.height[HEIGHT_W-1], b_stage.height});
    ph_w    = $signed({b_stage.base_height[HEIGHT_W-1], b_stage.base_height});
    thr_w   = $signed({{(BAND_W-THR_W){thr_c[THR_W-1]}}, thr_c});
    gen_w   = $signed({{(BAND_W-RADIUS_W){1'b0}}, b_stage.gen});
    band_hi = ph_w + thr_w;
    band_lo = ph_w - thr_w;

    c_next.in_band = (h_w <= band_hi) && (h_w >= band_lo);
    c_next.gen_ok  = (h_w <= gen_w) && (h_w >= -gen_w);
    c_next.recl_ok = b_stage.gt_recl && (h_w <= thr_w) && (h_w >= -thr_w);
    c_next.first   = b_stage.first;
    c_next.index   = b_stage.index;
  end

  // Output stage: past the input stage, the only dependence between neighboring points is the
  // ground flag, which is resolved here in one select.
  always_comb begin
    if (c_stage.in_band) begin
      ground_next = (last_was_ground && !c_stage.first) || c_stage.gen_ok;
    end else begin
      ground_next = c_stage.recl_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid         <= 1'b0;
      b_valid         <= 1'b0;
      c_valid         <= 1'b0;
      o_valid         <= 1'b0;
      last_was_ground <= 1'b0;
      last_radius     <= '0;
      last_height     <= '0;
    end else begin
      if (a_free) begin
        a_valid <= points.valid;
      end
      if (b_free) begin
        b_valid <= a_valid;
      end
      if (c_free) begin
        c_valid <= b_valid;
      end
      if (o_free) begin
        o_valid <= c_valid;
      end
      if (c_valid && o_free) begin
        last_was_ground <= ground_next;
      end
      if (in_acc) begin
        last_radius <= points.radius_mm;
        last_height <= points.height_mm;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_stage <= a_next;
    end
    if (a_valid && b_free) begin
      b_stage <= b_next;
    end
    if (b_valid && c_free) begin
      c_stage <= c_next;
    end
    if (c_valid && o_free) begin
      o_index  <= c_stage.index;
      o_ground <= ground_next;
    end
  end

  assign results.valid     = o_valid;
  assign results.out_index = o_index;
  assign results.is_ground = o_ground;

  // A point that starts a ray steps from zero radius.
  `RGPC_ASSERT_NEXT(a_ray_start_step, clk, rst, in_acc && points.first_of_ray,
    a_stage.step == STEP_W'($past(points.radius_mm)))
  // The recurrence register always agrees with the result on display.
  `RGPC_ASSERT_SAME(a_ground_state_matches, clk, rst, o_valid,
    last_was_ground == o_ground)
  // The minimum-height raise never leaves the threshold below the minimum.
  `RGPC_ASSERT_SAME(a_thr_raise, clk, rst, b_valid && b_stage.gt_div,
    thr_c >= min_thr)
  // A band result is held while the output register is blocked.
  `RGPC_ASSERT_NEXT(a_band_stage_holds, clk, rst, c_valid && !o_free,
    c_valid && $stable(c_stage))

endmodule
